### src/rsw_pkg.sv
// Package for the RTP sequence window tracker: event codes, queue command and
// slot record types, default sizes. No dependencies.
package rsw_pkg;

  localparam int unsigned DefWindowSize = 128;
  // widest slot index over the supported window range (up to 4096 slots)
  localparam int unsigned IdxMaxW = 12;
  localparam int unsigned CmdDepth = 2;
  localparam logic [31:0] SyncTimeoutRst = 32'd5;

  localparam logic REQ_RESTART = 1'b1;

  typedef enum logic [2:0] {
    EV_IN_ORDER = 3'd0,
    EV_LATE     = 3'd1,
    EV_JUMP     = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_EXPLICIT = 3'd4
  } event_e;

  typedef struct packed {
    event_e               ev;
    logic [15:0]          seq;
    logic [IdxMaxW-1:0]   idx;
    logic [15:0]          start_seq;
    logic [IdxMaxW-1:0]   start_idx;
    logic [IdxMaxW-1:0]   walk_cnt;
  } cmd_t;

  typedef struct packed {
    logic        recv;
    logic [15:0] seq;
  } slot_t;

endpackage

### src/rsw_if.sv
// Channel interfaces of the RTP sequence window tracker: request, result and
// configuration write. No dependencies.
interface rsw_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] seq_number;
  logic [31:0] now_time;
  modport source (output valid, req_type, seq_number, now_time, input ready);
  modport sink (input valid, req_type, seq_number, now_time, output ready);
endinterface

interface rsw_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        nack_valid;
  logic [15:0] first_lost_seq;
  logic [15:0] lost_mask;
  logic        already_received;
  modport source (output valid, event_res, nack_valid, first_lost_seq, lost_mask,
                  already_received, input ready);
  modport sink (input valid, event_res, nack_valid, first_lost_seq, lost_mask,
                already_received, output ready);
endinterface

interface rsw_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/rsw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rsw_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/rsw_cmd_fifo.sv
// Short command queue between classifier front and window back end.
// Depends on rsw_pkg.
module rsw_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rsw_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rsw_pkg::cmd_t pop_data_o
);
  import rsw_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(CmdDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/rsw_front.sv
// Front end: accepts requests and config writes, classifies each item against
// the newest number and time, reduces seq modulo the window, queues a command. Uses rsw_pkg.
module rsw_front #(
  parameter int unsigned WindowSize = rsw_pkg::DefWindowSize
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsw_req_if.sink       req_i,
  rsw_cfg_if.sink       cfg_i,
  input  logic          init_done_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output rsw_pkg::cmd_t cmd_o
);
  import rsw_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowSize);
  localparam logic [15:0] WinLim  = 16'(WindowSize);
  localparam logic [15:0] JumpLim = 16'(32'd65536 - WindowSize);
  // floor(s / W) == (s * ModMul) >> ModShift for every 16-bit s
  localparam int unsigned ModShift = 16 + IdxW;
  localparam logic [16:0] ModMul =
    17'(((64'd1 << ModShift) + 64'(WindowSize) - 64'd1) / 64'(WindowSize));

  typedef enum logic [1:0] {F_IDLE, F_MOD, F_REM, F_PUSH} fstate_e;

  fstate_e         state_q;
  logic [31:0]     sync_timeout_q;
  logic [15:0]     prev_seq_q;
  logic [31:0]     last_time_q;
  logic [IdxW-1:0] last_idx_q;
  logic            upd_idx_q;
  cmd_t            cmd_q;
  logic [15:0]     rem_q;
  logic [15:0]     quo_q;

  logic        accept;
  logic [31:0] dt;
  logic [15:0] seq_gap;
  event_e      ev;
  logic [32:0] quo_prod;
  logic [15:0] rem_prod;
  logic [15:0] walk;

  assign req_i.ready = (state_q == F_IDLE) && init_done_i;
  assign cfg_i.ready = 1'b1;
  assign accept = req_i.valid && req_i.ready;

  assign dt      = req_i.now_time - last_time_q;
  assign seq_gap = req_i.seq_number - prev_seq_q;

  always_comb begin
    priority if (req_i.req_type == REQ_RESTART) begin
      ev = EV_EXPLICIT;
    end else if (dt > sync_timeout_q) begin
      ev = EV_TIMEOUT;
    end else if (seq_gap < WinLim) begin
      ev = EV_IN_ORDER;
    end else if (seq_gap < JumpLim) begin
      ev = EV_JUMP;
    end else begin
      ev = EV_LATE;
    end
  end

  // skipped numbers strictly between the newest number and seq
  assign walk = ((ev == EV_IN_ORDER) && (seq_gap != 16'd0)) ? seq_gap - 16'd1 : 16'd0;

  // reciprocal multiply for the quotient, then one multiply-subtract for the slot
  assign quo_prod = 33'(cmd_q.seq) * 33'(ModMul);
  assign rem_prod = quo_q * WinLim;

  always_comb begin
    cmd_o     = cmd_q;
    cmd_o.idx = IdxMaxW'(rem_q);
  end
  assign cmd_valid_o = (state_q == F_PUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= F_IDLE;
      sync_timeout_q <= SyncTimeoutRst;
      prev_seq_q     <= '0;
      last_time_q    <= '0;
      last_idx_q     <= '0;
      upd_idx_q      <= 1'b0;
      cmd_q          <= '0;
      rem_q          <= '0;
      quo_q          <= '0;
    end else begin
      if (cfg_i.valid) begin
        sync_timeout_q <= cfg_i.data;
      end
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            cmd_q.ev        <= ev;
            cmd_q.seq       <= req_i.seq_number;
            cmd_q.idx       <= '0;
            cmd_q.start_seq <= prev_seq_q;
            cmd_q.start_idx <= IdxMaxW'(last_idx_q);
            cmd_q.walk_cnt  <= IdxMaxW'(walk);
            upd_idx_q       <= (ev != EV_LATE);
            if (ev != EV_LATE) begin
              prev_seq_q  <= req_i.seq_number;
              last_time_q <= req_i.now_time;
            end
            state_q <= F_MOD;
          end
        end
        F_MOD: begin
          quo_q   <= 16'(quo_prod >> ModShift);
          state_q <= F_REM;
        end
        F_REM: begin
          rem_q   <= cmd_q.seq - rem_prod;
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (cmd_ready_i) begin
            if (upd_idx_q) last_idx_q <= rem_q[IdxW-1:0];
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### src/rsw_back.sv
// Back end: carries out queued commands on the slot RAM (clear sweeps, slot
// update, loss walk with NACK build) and holds the result. Uses rsw_pkg.
module rsw_back #(
  parameter int unsigned WindowSize = rsw_pkg::DefWindowSize
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  rsw_pkg::cmd_t                   cmd_i,
  output logic                            init_done_o,
  output logic                            ram_we_o,
  output logic [$clog2(WindowSize)-1:0]   ram_waddr_o,
  output rsw_pkg::slot_t                  ram_wdata_o,
  output logic [$clog2(WindowSize)-1:0]   ram_raddr_o,
  input  rsw_pkg::slot_t                  ram_rdata_i,
  rsw_res_if.source                       res_o
);
  import rsw_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowSize);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowSize - 1);

  typedef enum logic [2:0] {B_INIT, B_IDLE, B_CHECK, B_CLEAR, B_WALK, B_OUT} bstate_e;

  // slot of m+1 given the slot j of m; 65535 wraps to slot 0
  function automatic logic [IdxW-1:0] step_idx(logic [IdxW-1:0] j, logic [15:0] m);
    return ((m == 16'hFFFF) || (j == LastIdx)) ? '0 : j + 1'b1;
  endfunction

  bstate_e         state_q;
  logic [IdxW-1:0] cnt_q;
  cmd_t            cmd_q;
  logic            already_q;
  logic            nv_q;
  logic [15:0]     first_q;
  logic [15:0]     mask_q;
  logic [IdxW-1:0] iss_left_q;
  logic [15:0]     iss_m_q;
  logic [IdxW-1:0] iss_j_q;
  logic            cmp_v_q;
  logic [15:0]     cmp_m_q;
  logic [IdxW-1:0] cmp_j_q;
  logic            fwd_v_q;
  logic [IdxW-1:0] fwd_addr_q;
  slot_t           fwd_data_q;

  logic [IdxW-1:0] seq_idx;
  slot_t           cmp_data;
  logic            lost;
  logic            issue;
  logic [15:0]     off;

  assign seq_idx = cmd_q.idx[IdxW-1:0];
  // the write of the previous step lands on the same edge as this read
  assign cmp_data = (fwd_v_q && (fwd_addr_q == cmp_j_q)) ? fwd_data_q : ram_rdata_i;
  assign lost  = cmp_v_q && (cmp_data.seq != cmp_m_q);
  assign issue = (iss_left_q != '0);
  assign off   = cmp_m_q - first_q - 16'd1;

  assign cmd_ready_o = (state_q == B_IDLE);
  assign init_done_o = (state_q != B_INIT);

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = '0;
    ram_raddr_o = iss_j_q;
    unique case (state_q)
      B_INIT: begin
        ram_we_o = 1'b1;
      end
      B_IDLE: begin
        ram_raddr_o = cmd_i.idx[IdxW-1:0];
      end
      B_CHECK: begin
        if ((cmd_q.ev == EV_IN_ORDER) || (cmd_q.ev == EV_LATE)) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = seq_idx;
          ram_wdata_o = '{recv: 1'b1, seq: cmd_q.seq};
        end
      end
      B_CLEAR: begin
        ram_we_o = 1'b1;
        if (cnt_q == seq_idx) ram_wdata_o = '{recv: 1'b1, seq: cmd_q.seq};
      end
      B_WALK: begin
        if (lost) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = cmp_j_q;
          ram_wdata_o = '{recv: 1'b0, seq: cmp_m_q};
        end
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid            = (state_q == B_OUT);
  assign res_o.event_res        = cmd_q.ev;
  assign res_o.nack_valid       = nv_q;
  assign res_o.first_lost_seq   = first_q;
  assign res_o.lost_mask        = mask_q;
  assign res_o.already_received = already_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_INIT;
      cnt_q      <= '0;
      cmd_q      <= '0;
      already_q  <= 1'b0;
      nv_q       <= 1'b0;
      first_q    <= '0;
      mask_q     <= '0;
      iss_left_q <= '0;
      iss_m_q    <= '0;
      iss_j_q    <= '0;
      cmp_v_q    <= 1'b0;
      cmp_m_q    <= '0;
      cmp_j_q    <= '0;
      fwd_v_q    <= 1'b0;
      fwd_addr_q <= '0;
      fwd_data_q <= '0;
    end else begin
      fwd_v_q    <= ram_we_o;
      fwd_addr_q <= ram_waddr_o;
      fwd_data_q <= ram_wdata_o;
      unique case (state_q)
        B_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            nv_q    <= 1'b0;
            first_q <= '0;
            mask_q  <= '0;
            state_q <= B_CHECK;
          end
        end
        B_CHECK: begin
          already_q <= ram_rdata_i.recv && (ram_rdata_i.seq == cmd_q.seq);
          unique case (cmd_q.ev)
            EV_IN_ORDER: begin
              iss_m_q    <= cmd_q.start_seq + 16'd1;
              iss_j_q    <= step_idx(cmd_q.start_idx[IdxW-1:0], cmd_q.start_seq);
              iss_left_q <= cmd_q.walk_cnt[IdxW-1:0];
              state_q    <= (cmd_q.walk_cnt == '0) ? B_OUT : B_WALK;
            end
            EV_LATE: state_q <= B_OUT;
            default: begin
              cnt_q   <= '0;
              state_q <= B_CLEAR;
            end
          endcase
        end
        B_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= B_OUT;
          end
        end
        B_WALK: begin
          cmp_v_q <= issue;
          if (issue) begin
            cmp_m_q    <= iss_m_q;
            cmp_j_q    <= iss_j_q;
            iss_m_q    <= iss_m_q + 16'd1;
            iss_j_q    <= step_idx(iss_j_q, iss_m_q);
            iss_left_q <= iss_left_q - 1'b1;
          end
          if (lost) begin
            if (!nv_q) begin
              nv_q    <= 1'b1;
              first_q <= cmp_m_q;
            end else if (off < 16'd16) begin
              mask_q[off[3:0]] <= 1'b1;
            end
          end
          if (!issue && cmp_v_q) state_q <= B_OUT;
        end
        B_OUT: begin
          if (res_o.ready) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

### src/rtp_seq_window_nack.sv
// RTP sequence window tracker with generic NACK. Front steps: accept, reciprocal
// multiply for seq mod W, remainder, push. Back: slot check and update for a late item or
// an in-order step of 0 or 1, plus a loss walk (one slot per cycle) for an in-order advance
// by d >= 2, or a full slot clear sweep for any restart. The front takes no new request until
// its command is pushed; the two-entry queue lets the front run ahead of the back end.
// Reset: async active low; then a clearing pass over all W slots with no request taken.
module rtp_seq_window_nack #(
  parameter int unsigned WindowSize = rsw_pkg::DefWindowSize
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsw_req_if.sink    req_i,
  rsw_cfg_if.sink    cfg_i,
  rsw_res_if.source  res_o
);
  import rsw_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowSize);

  // front -> queue
  logic  fq_valid, fq_ready;
  cmd_t  fq_cmd;
  // queue -> back
  logic  qb_valid, qb_ready;
  cmd_t  qb_cmd;
  logic  init_done;

  // slot RAM port
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  slot_t           ram_wdata, ram_rdata;

  // classification, modulo reduction, newest seq/time, sync_timeout
  rsw_front #(.WindowSize(WindowSize)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .init_done_i (init_done),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // decouples classifier from window work
  rsw_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  // slot updates, restart clears, loss walk; owns the result register
  rsw_back #(.WindowSize(WindowSize)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .init_done_o (init_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (res_o)
  );

  // {received, seq} per slot
  rsw_ram #(.Width($bits(slot_t)), .Depth(WindowSize)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // only an in-order advance can report losses
  a_nack_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.event_res != EV_IN_ORDER) |-> !res_o.nack_valid)
    else $error("NACK on a non in-order event");

  // without a NACK the id and mask read zero
  a_nack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.nack_valid |->
      (res_o.first_lost_seq == 16'd0) && (res_o.lost_mask == 16'd0))
    else $error("NACK fields set without nack_valid");

  // no request taken while the slot clearing pass runs
  a_init_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !req_i.ready)
    else $error("request ready during slot clear");

  // back end never produces a result while still clearing after reset
  a_init_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !res_o.valid && !qb_ready)
    else $error("back end active during slot clear");
`endif

endmodule
